@@ sv/frer_pkg.sv @@
// Package for the frame rate estimator: sizes, register indexes, constants,
// the rounding function and the control record of the trimming accumulator.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package frer_pkg;

    localparam int HIST_BINS  = 1024;
    localparam int BIN_W      = $clog2(HIST_BINS);
    localparam int CNT16_W    = 16;
    localparam int TIME_W     = 32;
    localparam int WIN_W      = 20;
    localparam int RATE_W     = 6;
    localparam int CUM_W      = CNT16_W + BIN_W;
    localparam int CNT_W      = CNT16_W + BIN_W;
    localparam int PROD_W     = CNT16_W + BIN_W;
    localparam int SUM_W      = CNT16_W + 2 * BIN_W;
    localparam int Q_W        = (BIN_W > 10) ? BIN_W : 10;
    localparam int DIV_W      = (SUM_W > CNT_W + Q_W) ? SUM_W : CNT_W + Q_W;
    localparam int STEP_W     = $clog2(Q_W);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVALS = 2'd1;

    localparam logic [WIN_W-1:0]   WINDOW_RESET    = 20'd10000;
    localparam logic [CNT16_W-1:0] MIN_RESET       = 16'd30;
    localparam logic [CNT16_W-1:0] MIN_CLOSE_TOTAL = 16'd6;
    localparam logic [CNT16_W-1:0] COUNT_MAX       = 16'hFFFF;
    localparam logic [BIN_W-1:0]   LAST_BIN        = BIN_W'(HIST_BINS - 1);
    localparam logic [SUM_W-1:0]   MS_PER_S        = SUM_W'(1000);

    // Reciprocal of three: (t * 43691) >> 17 equals t / 3 for any 16-bit t.
    localparam logic [16:0] THIRD_RECIP = 17'd43691;
    localparam int          THIRD_SHIFT = 17;

    localparam logic [RATE_W-1:0] RATE_1  = 6'd1;
    localparam logic [RATE_W-1:0] RATE_5  = 6'd5;
    localparam logic [RATE_W-1:0] RATE_10 = 6'd10;
    localparam logic [RATE_W-1:0] RATE_15 = 6'd15;
    localparam logic [RATE_W-1:0] RATE_30 = 6'd30;
    localparam logic [RATE_W-1:0] RATE_50 = 6'd50;
    localparam logic [RATE_W-1:0] RATE_60 = 6'd60;

    typedef struct packed {
        logic             clear;
        logic             valid;
        logic [BIN_W-1:0] bin;
    } trim_ctrl_t;

    function automatic logic [RATE_W-1:0] round_rate(input logic [Q_W-1:0] fps);
        logic [RATE_W-1:0] r;
        if (fps >= Q_W'(55)) begin
            r = RATE_60;
        end else if (fps >= Q_W'(40)) begin
            r = RATE_50;
        end else if (fps >= Q_W'(20)) begin
            r = RATE_30;
        end else if (fps >= Q_W'(12)) begin
            r = RATE_15;
        end else if (fps >= Q_W'(7)) begin
            r = RATE_10;
        end else if (fps >= Q_W'(3)) begin
            r = RATE_5;
        end else begin
            r = RATE_1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/frer_hist_ram.sv @@
// Interval histogram store: one write port and one read port with a
// registered read. Depends on frer_pkg for its depth and widths.
`default_nettype none

module frer_hist_ram (
    input  wire logic                       aclk,
    input  wire logic                       rd_en,
    input  wire logic [frer_pkg::BIN_W-1:0] rd_addr,
    input  wire logic                       wr_en,
    input  wire logic [frer_pkg::BIN_W-1:0] wr_addr,
    input  wire logic [frer_pkg::CNT16_W-1:0] wr_data,
    output logic      [frer_pkg::CNT16_W-1:0] rd_data
);

    logic [frer_pkg::CNT16_W-1:0] mem [frer_pkg::HIST_BINS];
    logic [frer_pkg::CNT16_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ sv/frer_trim_acc.sv @@
// Trimmed-mean accumulator: walks the bins in order, keeps the cumulative
// count and sums only the middle third. Depends on frer_pkg.
`default_nettype none

module frer_trim_acc (
    input  wire logic                         aclk,
    input  wire frer_pkg::trim_ctrl_t         ctrl,
    input  wire logic [frer_pkg::CNT16_W-1:0] value,
    input  wire logic [frer_pkg::CNT16_W-1:0] skip,
    input  wire logic [frer_pkg::CNT16_W-1:0] upper,
    output logic      [frer_pkg::SUM_W-1:0]   sum,
    output logic      [frer_pkg::CNT_W-1:0]   cnt
);

    logic [frer_pkg::CUM_W-1:0]  cum_reg;
    logic [frer_pkg::PROD_W-1:0] prod_reg;
    logic [frer_pkg::CNT16_W-1:0] part_reg;
    logic [frer_pkg::SUM_W-1:0]  sum_reg;
    logic [frer_pkg::CNT_W-1:0]  cnt_reg;
    logic [frer_pkg::CUM_W-1:0]  cum_next;
    logic                        in_range;

    assign cum_next = cum_reg + frer_pkg::CUM_W'(value);
    assign in_range = (cum_next > frer_pkg::CUM_W'(skip)) &&
                      (cum_next <= frer_pkg::CUM_W'(upper));

    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            cum_reg  <= '0;
            prod_reg <= '0;
            part_reg <= '0;
            sum_reg  <= '0;
            cnt_reg  <= '0;
        end else begin
            if (ctrl.valid) begin
                cum_reg <= cum_next;
            end
            if (ctrl.valid && in_range) begin
                prod_reg <= frer_pkg::PROD_W'(ctrl.bin) * frer_pkg::PROD_W'(value);
                part_reg <= value;
            end else begin
                prod_reg <= '0;
                part_reg <= '0;
            end
            sum_reg <= sum_reg + frer_pkg::SUM_W'(prod_reg);
            cnt_reg <= cnt_reg + frer_pkg::CNT_W'(part_reg);
        end
    end

    assign sum = sum_reg;
    assign cnt = cnt_reg;

endmodule

`default_nettype wire

@@ sv/frer_div.sv @@
// Restoring divider, one quotient bit per cycle, for quotients known to fit
// in Q_W bits. Shared by the mean and the rate conversion. Depends on frer_pkg.
`default_nettype none

module frer_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [frer_pkg::SUM_W-1:0]  dividend,
    input  wire logic [frer_pkg::CNT_W-1:0]  divisor,
    output logic                             done,
    output logic      [frer_pkg::Q_W-1:0]    quotient
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [frer_pkg::STEP_W-1:0]   step_reg;
    logic [frer_pkg::DIV_W-1:0]    rem_reg;
    logic [frer_pkg::DIV_W-1:0]    dsh_reg;
    logic [frer_pkg::Q_W-1:0]      q_reg;
    logic                          fits;

    assign fits = rem_reg >= dsh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == frer_pkg::STEP_W'(frer_pkg::Q_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= frer_pkg::DIV_W'(dividend);
            dsh_reg <= frer_pkg::DIV_W'(divisor) << (frer_pkg::Q_W - 1);
            q_reg   <= '0;
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= rem_reg - dsh_reg;
            end
            dsh_reg <= dsh_reg >> 1;
            q_reg   <= {q_reg[frer_pkg::Q_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

@@ sv/frame_rate_estimator_unit.sv @@
// Frame rate estimator, top level: sequencer around the histogram store,
// the trimming accumulator and the shared divider.
// Depends on frer_pkg, frer_hist_ram, frer_trim_acc and frer_div.
//
// Each request on the s_ channel is one frame: its timestamp and the current
// millisecond clock. Each request yields exactly one result on the m_ channel:
// the latest rounded frame rate and a flag that is set when this frame closed
// a measurement window. The two registers are written through the cfg_ port;
// the user must write them only while the block is idle; it does not enforce this.
// An ordinary frame passes through S_INC, which does the read-modify-write of
// its histogram bin, then S_CHECK and S_OUT; one with no interval skips S_INC.
// A frame that closes a window walks the histogram, reading and clearing every
// bin at one bin per cycle, then the divider runs up to twice at one quotient
// bit per cycle. A new frame is taken only after the previous one has left
// S_OUT; s_ready is high only while idle.
// After reset the block clears every histogram bin before it takes its
// first request; configuration writes are taken meanwhile.
// The result waits in an output register, so a stalled receiver does not
// stop the next request from being accepted; only the following result waits.
`default_nettype none

module frame_rate_estimator_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [frer_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [frer_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [frer_pkg::TIME_W-1:0]       s_frame_time_ms,
    input  wire logic [frer_pkg::TIME_W-1:0]       s_clock_now_ms,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic      [frer_pkg::RATE_W-1:0]       m_frame_rate,
    output logic                                   m_rate_updated
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_INC    = 4'd2;
    localparam logic [3:0] S_CHECK  = 4'd3;
    localparam logic [3:0] S_PREP   = 4'd4;
    localparam logic [3:0] S_WALK   = 4'd5;
    localparam logic [3:0] S_DRAIN  = 4'd6;
    localparam logic [3:0] S_DECIDE = 4'd7;
    localparam logic [3:0] S_DIV1   = 4'd8;
    localparam logic [3:0] S_DIV2   = 4'd9;
    localparam logic [3:0] S_OUT    = 4'd10;

    logic [3:0] state_reg, state_next;
    logic [frer_pkg::BIN_W-1:0]   addr_reg, addr_next;
    logic [frer_pkg::BIN_W-1:0]   bin_reg, bin_next;
    logic [frer_pkg::TIME_W-1:0]  prev_reg, prev_next;
    logic [frer_pkg::TIME_W-1:0]  now_reg, now_next;
    logic [frer_pkg::TIME_W-1:0]  ws_reg, ws_next;
    logic [frer_pkg::CNT16_W-1:0] total_reg, total_next;
    logic [frer_pkg::CNT16_W-1:0] skip_reg, skip_next;
    logic [frer_pkg::RATE_W-1:0]  rate_reg, rate_next;
    logic [frer_pkg::WIN_W-1:0]   win_len_reg, win_len_next;
    logic [frer_pkg::CNT16_W-1:0] min_cnt_reg, min_cnt_next;
    logic                         close_reg, close_next;
    logic                         m_valid_reg, m_valid_next;
    logic [frer_pkg::RATE_W-1:0]  m_frame_rate_reg, m_frame_rate_next;
    logic                         m_rate_updated_reg, m_rate_updated_next;

    logic                         rd_en, wr_en;
    logic [frer_pkg::BIN_W-1:0]   rd_addr, wr_addr;
    logic [frer_pkg::CNT16_W-1:0] wr_data, rd_data;
    frer_pkg::trim_ctrl_t         trim_ctrl;
    logic [frer_pkg::CNT16_W-1:0] upper;
    logic [frer_pkg::SUM_W-1:0]   sum;
    logic [frer_pkg::CNT_W-1:0]   cnt;
    logic                         div_start, div_done;
    logic [frer_pkg::SUM_W-1:0]   div_dividend;
    logic [frer_pkg::CNT_W-1:0]   div_divisor;
    logic [frer_pkg::Q_W-1:0]     quotient;

    logic [frer_pkg::TIME_W-1:0]  interval;
    logic [frer_pkg::BIN_W-1:0]   in_bin;
    logic [frer_pkg::TIME_W-1:0]  ws_eff;
    logic [frer_pkg::TIME_W-1:0]  duration;
    logic [32:0]                  third_prod;

    assign interval   = s_frame_time_ms - prev_reg;
    assign in_bin     = (interval >= frer_pkg::TIME_W'(frer_pkg::HIST_BINS - 1)) ?
                        frer_pkg::LAST_BIN : interval[frer_pkg::BIN_W-1:0];
    assign ws_eff     = (ws_reg == '0) ? now_reg : ws_reg;
    assign duration   = now_reg - ws_eff;
    assign third_prod = 33'(total_reg) * 33'(frer_pkg::THIRD_RECIP);
    assign upper      = total_reg - skip_reg;

    assign div_dividend = (state_reg == S_DIV1) ? frer_pkg::MS_PER_S : sum;
    assign div_divisor  = (state_reg == S_DIV1) ? frer_pkg::CNT_W'(quotient) : cnt;

    frer_hist_ram u_hist (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    frer_trim_acc u_trim (
        .aclk  (aclk),
        .ctrl  (trim_ctrl),
        .value (rd_data),
        .skip  (skip_reg),
        .upper (upper),
        .sum   (sum),
        .cnt   (cnt)
    );

    frer_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb begin
        state_next          = state_reg;
        addr_next           = addr_reg;
        bin_next            = bin_reg;
        prev_next           = prev_reg;
        now_next            = now_reg;
        ws_next             = ws_reg;
        total_next          = total_reg;
        skip_next           = skip_reg;
        rate_next           = rate_reg;
        win_len_next        = win_len_reg;
        min_cnt_next        = min_cnt_reg;
        close_next          = close_reg;
        m_valid_next        = m_valid_reg && !m_ready;
        m_frame_rate_next   = m_frame_rate_reg;
        m_rate_updated_next = m_rate_updated_reg;
        rd_en               = 1'b0;
        rd_addr             = addr_reg;
        wr_en               = 1'b0;
        wr_addr             = addr_reg;
        wr_data             = '0;
        trim_ctrl           = '{clear: 1'b0, valid: 1'b0, bin: addr_reg};
        div_start           = 1'b0;
        s_ready             = 1'b0;

        if (cfg_wr_en) begin
            unique case (cfg_index)
                frer_pkg::REG_WINDOW_LENGTH: win_len_next = cfg_wdata;
                frer_pkg::REG_MIN_INTERVALS: min_cnt_next = cfg_wdata[frer_pkg::CNT16_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            S_CLEAR: begin
                wr_en     = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == frer_pkg::LAST_BIN) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    prev_next = s_frame_time_ms;
                    now_next  = s_clock_now_ms;
                    if (prev_reg != '0) begin
                        bin_next   = in_bin;
                        rd_en      = 1'b1;
                        rd_addr    = in_bin;
                        state_next = S_INC;
                    end else begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_INC: begin
                wr_en   = 1'b1;
                wr_addr = bin_reg;
                wr_data = (rd_data == frer_pkg::COUNT_MAX) ? rd_data : rd_data + 1'b1;
                if (total_reg != frer_pkg::COUNT_MAX) begin
                    total_next = total_reg + 1'b1;
                end
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (duration >= frer_pkg::TIME_W'(win_len_reg) && total_reg >= min_cnt_reg) begin
                    ws_next    = now_reg;
                    skip_next  = third_prod[frer_pkg::THIRD_SHIFT +: frer_pkg::CNT16_W];
                    close_next = 1'b1;
                    addr_next  = '0;
                    state_next = S_PREP;
                end else begin
                    ws_next    = ws_eff;
                    close_next = 1'b0;
                    state_next = S_OUT;
                end
            end
            S_PREP: begin
                rd_en           = 1'b1;
                trim_ctrl.clear = 1'b1;
                state_next      = S_WALK;
            end
            S_WALK: begin
                rd_en           = addr_reg != frer_pkg::LAST_BIN;
                rd_addr         = addr_reg + 1'b1;
                wr_en           = 1'b1;
                trim_ctrl.valid = 1'b1;
                addr_next       = addr_reg + 1'b1;
                if (addr_reg == frer_pkg::LAST_BIN) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                if (total_reg >= frer_pkg::MIN_CLOSE_TOTAL && cnt != '0) begin
                    div_start  = 1'b1;
                    state_next = S_DIV1;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_DIV1: begin
                if (div_done) begin
                    if (quotient == '0) begin
                        state_next = S_OUT;
                    end else begin
                        div_start  = 1'b1;
                        state_next = S_DIV2;
                    end
                end
            end
            S_DIV2: begin
                if (div_done) begin
                    rate_next  = frer_pkg::round_rate(quotient);
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next        = 1'b1;
                    m_frame_rate_next   = rate_reg;
                    m_rate_updated_next = close_reg;
                    if (close_reg) begin
                        total_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
                addr_next  = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            addr_reg    <= '0;
            prev_reg    <= '0;
            ws_reg      <= '0;
            total_reg   <= '0;
            rate_reg    <= frer_pkg::RATE_30;
            win_len_reg <= frer_pkg::WINDOW_RESET;
            min_cnt_reg <= frer_pkg::MIN_RESET;
            close_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            addr_reg    <= addr_next;
            prev_reg    <= prev_next;
            ws_reg      <= ws_next;
            total_reg   <= total_next;
            rate_reg    <= rate_next;
            win_len_reg <= win_len_next;
            min_cnt_reg <= min_cnt_next;
            close_reg   <= close_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bin_reg            <= bin_next;
        now_reg            <= now_next;
        skip_reg           <= skip_next;
        m_frame_rate_reg   <= m_frame_rate_next;
        m_rate_updated_reg <= m_rate_updated_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_frame_rate   = m_frame_rate_reg;
    assign m_rate_updated = m_rate_updated_reg;

endmodule

`default_nettype wire

@@ sv/frer_checker.sv @@
// Port-level checks for the frame rate estimator, attached by bind.
// Depends on frer_pkg and on the ports of frame_rate_estimator_unit.
`default_nettype none

module frer_assertions (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_valid,
    input wire logic                              s_ready,
    input wire logic                              m_valid,
    input wire logic                              m_ready,
    input wire logic [frer_pkg::RATE_W-1:0]       m_frame_rate,
    input wire logic                              m_rate_updated
);

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("outputs not quiet after reset");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while the previous one is still in work");

    a_rate_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_frame_rate == frer_pkg::RATE_1 || m_frame_rate == frer_pkg::RATE_5 ||
                     m_frame_rate == frer_pkg::RATE_10 || m_frame_rate == frer_pkg::RATE_15 ||
                     m_frame_rate == frer_pkg::RATE_30 || m_frame_rate == frer_pkg::RATE_50 ||
                     m_frame_rate == frer_pkg::RATE_60))
        else $error("frame rate outside the rounding set");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_frame_rate) && $stable(m_rate_updated))
        else $error("stalled result changed");

endmodule

bind frame_rate_estimator_unit frer_assertions u_frer_assertions (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_frame_rate   (m_frame_rate),
    .m_rate_updated (m_rate_updated)
);

`default_nettype wire
